// ===== src/pbta_pkg.sv =====
// Shared widths, style codes and fixed constants of the procedural brush tip alpha block.
package pbta_pkg;

   // Default tip edge length in pixels
   localparam int PBTA_TIP_SIZE = 64;

   // Port widths
   localparam int COORD_W = 6;
   localparam int STYLE_W = 2;
   localparam int ALPHA_W = 8;

   // Datapath widths: squared distance, Q1.16 fraction, square root
   localparam int D2_W    = 16;
   localparam int FRAC_W  = 16;
   localparam int ROOT_W  = D2_W / 2 + FRAC_W;
   localparam int REM_W   = ROOT_W + 1;

   // Square root pipeline: result bits resolved per stage
   localparam int SQ_PER_STAGE = 2;
   localparam int SQ_STAGES    = ROOT_W / SQ_PER_STAGE;

   // Cycles from an accepted request to its response strobe
   localparam int PIPE_LAT = SQ_STAGES + 9;

   // Tip style codes
   typedef enum logic [STYLE_W-1:0] {
      STYLE_CHARCOAL = 2'd0,
      STYLE_CONCEPT  = 2'd1,
      STYLE_PENCIL   = 2'd2
   } style_type;

   // Hash multipliers: only the low byte of each 32-bit constant reaches the hash byte
   localparam logic [7:0] HASH_CH_X = 8'd93;
   localparam logic [7:0] HASH_CH_Y = 8'd159;
   localparam logic [7:0] HASH_CO   = 8'd177;
   localparam logic [7:0] HASH_PE_X = 8'd247;
   localparam logic [7:0] HASH_PE_Y = 8'd75;

   // Hardness (Q0.16)
   localparam logic [FRAC_W-1:0] HARD_CH = 16'd22938;
   localparam logic [FRAC_W-1:0] HARD_CO = 16'd36045;
   localparam logic [FRAC_W-1:0] HARD_PE = 16'd49152;

   // Grain offset and span (Q0.16)
   localparam logic [FRAC_W-1:0] GRAIN0_CH = 16'd42598;
   localparam logic [FRAC_W-1:0] GRAIN0_CO = 16'd53740;
   localparam logic [FRAC_W-1:0] GRAIN0_PE = 16'd36045;
   localparam logic [FRAC_W-1:0] GRAIN1_CH = 16'd22938;
   localparam logic [FRAC_W-1:0] GRAIN1_CO = 16'd11796;
   localparam logic [FRAC_W-1:0] GRAIN1_PE = 16'd29491;

   // One in Q1.16
   localparam logic [FRAC_W:0] Q_ONE = 17'd65536;

endpackage

// ===== src/procedural_brush_tip_alpha.sv =====
// Procedural brush tip alpha: pipelined distance, falloff and grain for one tip pixel per clock.
//
//   channel   ports                                 handshake
//   --------  ------------------------------------  --------------------------------
//   request   req_px_x, req_px_y                    taken when start && !busy
//   response  rsp_tip_alpha                         one cycle, marked by rsp_valid
//   csr       csr_wr_data (tip_style)               written when csr_wr_en
//
// One pixel enters per clock; each request passes stages 0, 1 and 2, the square root stages,
// stages A to E and the output register. The depth is set by the square root, two result bits
// per stage. busy follows reset: no transaction is taken while reset is high, and reset drops
// all transactions in flight. The receiver cannot stall, so the pipeline never holds.
module procedural_brush_tip_alpha #(
   parameter int TIP_SIZE = pbta_pkg::PBTA_TIP_SIZE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pbta_pkg::COORD_W-1:0]  req_px_x,
   input  logic [pbta_pkg::COORD_W-1:0]  req_px_y,
   input  logic                          csr_wr_en,
   input  logic [pbta_pkg::STYLE_W-1:0]  csr_wr_data,
   output logic                          rsp_valid,
   output logic [pbta_pkg::ALPHA_W-1:0]  rsp_tip_alpha
);
   import pbta_pkg::*;

   // Geometry per style
   localparam int CENTER = TIP_SIZE / 2;
   localparam int R_CH   = (TIP_SIZE / 2 - 2 < 1) ? 1 : TIP_SIZE / 2 - 2;
   localparam int R_CO   = (TIP_SIZE / 2 - 1 < 1) ? 1 : TIP_SIZE / 2 - 1;
   localparam int R_PE   = (TIP_SIZE / 4 < 1) ? 1 : TIP_SIZE / 4;
   localparam int RAD_W  = $clog2(TIP_SIZE / 2);
   // Offsets must hold any coordinate the ports can carry, inside the tip or not
   localparam int DX_W   =
      ((COORD_W > $clog2(TIP_SIZE)) ? COORD_W : $clog2(TIP_SIZE)) + 2;

   // Radius reciprocals, ceil(2^ROOT_W / r)
   localparam logic [ROOT_W-1:0] RCP_CH =
      ROOT_W'(((64'd1 << ROOT_W) + 64'(R_CH) - 64'd1) / 64'(R_CH));
   localparam logic [ROOT_W-1:0] RCP_CO =
      ROOT_W'(((64'd1 << ROOT_W) + 64'(R_CO) - 64'd1) / 64'(R_CO));
   localparam logic [ROOT_W-1:0] RCP_PE =
      ROOT_W'(((64'd1 << ROOT_W) + 64'(R_PE) - 64'd1) / 64'(R_PE));

   // Falloff span (one minus hardness) and its reciprocal, ceil(2^32 / span)
   localparam int FRCP_W = FRAC_W + 3;
   localparam logic [FRAC_W-1:0] FDIV_CH = FRAC_W'(32'd65536 - 32'(HARD_CH));
   localparam logic [FRAC_W-1:0] FDIV_CO = FRAC_W'(32'd65536 - 32'(HARD_CO));
   localparam logic [FRAC_W-1:0] FDIV_PE = FRAC_W'(32'd65536 - 32'(HARD_PE));
   localparam logic [FRCP_W-1:0] FRCP_CH =
      FRCP_W'(((64'd1 << (2 * FRAC_W)) + 64'(FDIV_CH) - 64'd1) / 64'(FDIV_CH));
   localparam logic [FRCP_W-1:0] FRCP_CO =
      FRCP_W'(((64'd1 << (2 * FRAC_W)) + 64'(FDIV_CO) - 64'd1) / 64'(FDIV_CO));
   localparam logic [FRCP_W-1:0] FRCP_PE =
      FRCP_W'(((64'd1 << (2 * FRAC_W)) + 64'(FDIV_PE) - 64'd1) / 64'(FDIV_PE));

   // Grain division by 255: estimate by ceil(2^23 / 255), then one correction
   localparam int P_W         = FRAC_W + 8;
   localparam int GRAIN_SHIFT = 23;
   localparam logic [15:0] GRCP = 16'(((64'd1 << GRAIN_SHIFT) + 64'd254) / 64'd255);
   localparam logic [7:0]  N_MAX = 8'd255;

   // Square root stage record
   typedef struct packed {
      logic              v;
      style_type         st;
      logic [P_W-1:0]    p;
      logic [D2_W-1:0]   d2;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   // Two digit steps of the restoring square root of d2 * 2^32
   function automatic sq_type sq_stage(input sq_type src, input int stage);
      sq_type           s;
      logic [1:0]       pr;
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      int               pi;
      s = src;
      for (int k = 0; k < SQ_PER_STAGE; k++) begin
         pi = ROOT_W - 1 - (stage * SQ_PER_STAGE + k);
         if (pi >= FRAC_W) begin
            pr = 2'(s.d2 >> (2 * (pi - FRAC_W)));
         end else begin
            pr = 2'b00;
         end
         rem_sh = {s.rem, pr};
         trial  = {1'b0, s.root, 2'b01};
         if (rem_sh >= trial) begin
            s.rem  = REM_W'(rem_sh - trial);
            s.root = {s.root[ROOT_W-2:0], 1'b1};
         end else begin
            s.rem  = rem_sh[REM_W-1:0];
            s.root = {s.root[ROOT_W-2:0], 1'b0};
         end
      end
      return s;
   endfunction

   // Configuration
   style_type tip_style_ff;

   // Stage 0: captured request
   logic               v0_ff;
   logic [COORD_W-1:0] x0_ff, y0_ff;
   style_type          st0_ff;

   // Stage 1: squared distance and hash byte
   logic              v1_ff;
   logic [D2_W-1:0]   d2_1_ff, d2_1_in;
   logic [7:0]        n1_ff, n1_in;
   style_type         st1_ff;

   // Stage 2: grain span times hash byte
   logic              v2_ff;
   logic [D2_W-1:0]   d2_2_ff;
   logic [P_W-1:0]    p2_ff, p2_in;
   style_type         st2_ff;

   // Square root stages
   sq_type sq_head;
   sq_type sq_ff [SQ_STAGES];
   sq_type sq_in [SQ_STAGES];
   sq_type sq_last;

   // Stage A: quotient estimates
   logic              va_ff;
   style_type         sta_ff;
   logic [ROOT_W-1:0] sa_ff;
   logic [ROOT_W-1:0] dqa_ff, dqa_in;
   logic [P_W-1:0]    pa_ff;
   logic [15:0]       gqa_ff, gqa_in;

   // Stage B: corrected distance and grain
   logic              vb_ff;
   style_type         stb_ff;
   logic [ROOT_W-1:0] db_ff, db_in;
   logic [FRAC_W:0]   grb_ff, grb_in;

   // Stage C: region flags and falloff estimate
   logic              vc_ff;
   style_type         stc_ff;
   logic              farc_ff, farc_in;
   logic              hardc_ff, hardc_in;
   logic [FRAC_W-1:0] uc_ff, uc_in;
   logic [FRAC_W:0]   efc_ff, efc_in;
   logic [FRAC_W:0]   grc_ff;

   // Stage D: falloff
   logic              vd_ff;
   style_type         std_ff;
   logic [FRAC_W:0]   based_ff, based_in;
   logic [FRAC_W:0]   grd_ff;

   // Stage E: falloff times grain
   logic                    ve_ff;
   style_type               ste_ff;
   logic [2*FRAC_W+1:0]     prode_ff, prode_in;

   // Output register
   logic               rsp_valid_ff;
   logic [ALPHA_W-1:0] rsp_tip_alpha_ff, rsp_tip_alpha_in;

   assign busy = reset;

   // Stage 1: offsets from center, squares, hash byte
   always_comb begin
      logic signed [DX_W-1:0]   dx, dy;
      logic signed [2*DX_W-1:0] dxx, dyy;
      dx  = $signed(DX_W'(x0_ff)) - $signed(DX_W'(CENTER));
      dy  = $signed(DX_W'(y0_ff)) - $signed(DX_W'(CENTER));
      dxx = dx * dx;
      dyy = dy * dy;
      d2_1_in = D2_W'(dxx) + D2_W'(dyy);
      unique case (st0_ff)
         STYLE_CHARCOAL: n1_in = (8'(x0_ff) * HASH_CH_X) ^ (8'(y0_ff) * HASH_CH_Y);
         STYLE_CONCEPT:  n1_in = (8'(x0_ff) + 8'(y0_ff) * 8'd3) * HASH_CO;
         STYLE_PENCIL:   n1_in = (8'(x0_ff) * HASH_PE_X) ^ (8'(y0_ff) * HASH_PE_Y);
         default:        n1_in = '0;
      endcase
   end

   // Stage 2: grain span times hash byte
   always_comb begin
      logic [FRAC_W-1:0] g1;
      unique case (st1_ff)
         STYLE_CONCEPT: g1 = GRAIN1_CO;
         STYLE_PENCIL:  g1 = GRAIN1_PE;
         default:       g1 = GRAIN1_CH;
      endcase
      p2_in = g1 * n1_ff;
   end

   // Square root chain
   always_comb begin
      sq_head.v    = v2_ff;
      sq_head.st   = st2_ff;
      sq_head.p    = p2_ff;
      sq_head.d2   = d2_2_ff;
      sq_head.rem  = '0;
      sq_head.root = '0;
   end

   for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
      if (j == 0) begin : g_first
         assign sq_in[j] = sq_stage(sq_head, j);
      end else begin : g_next
         assign sq_in[j] = sq_stage(sq_ff[j-1], j);
      end
   end

   assign sq_last = sq_ff[SQ_STAGES-1];

   // Stage A: root over radius and grain product over 255, by reciprocal
   always_comb begin
      logic [ROOT_W-1:0]   rcp;
      logic [2*ROOT_W-1:0] dprod;
      logic [P_W+15:0]     gprod;
      unique case (sq_last.st)
         STYLE_CONCEPT: rcp = RCP_CO;
         STYLE_PENCIL:  rcp = RCP_PE;
         default:       rcp = RCP_CH;
      endcase
      dprod  = (2*ROOT_W)'(sq_last.root) * (2*ROOT_W)'(rcp);
      dqa_in = dprod[2*ROOT_W-1:ROOT_W];
      gprod  = (P_W+16)'(sq_last.p) * (P_W+16)'(GRCP);
      gqa_in = gprod[GRAIN_SHIFT+15:GRAIN_SHIFT];
   end

   // Stage B: one-step corrections, grain offset
   always_comb begin
      logic [RAD_W-1:0]        rad;
      logic [FRAC_W-1:0]       g0;
      logic [ROOT_W+RAD_W-1:0] dchk;
      logic [P_W-1:0]          gchk;
      logic [15:0]             gq;
      unique case (sta_ff)
         STYLE_CONCEPT: begin
            rad = RAD_W'(R_CO);
            g0  = GRAIN0_CO;
         end
         STYLE_PENCIL: begin
            rad = RAD_W'(R_PE);
            g0  = GRAIN0_PE;
         end
         default: begin
            rad = RAD_W'(R_CH);
            g0  = GRAIN0_CH;
         end
      endcase
      dchk = (ROOT_W+RAD_W)'(dqa_ff) * (ROOT_W+RAD_W)'(rad);
      if (dchk > (ROOT_W+RAD_W)'(sa_ff)) begin
         db_in = dqa_ff - 1'b1;
      end else begin
         db_in = dqa_ff;
      end
      gchk = P_W'(gqa_ff) * P_W'(N_MAX);
      if (gchk > pa_ff) begin
         gq = gqa_ff - 1'b1;
      end else begin
         gq = gqa_ff;
      end
      grb_in = (FRAC_W+1)'(g0) + (FRAC_W+1)'(gq);
   end

   // Stage C: region flags, falloff quotient estimate
   always_comb begin
      logic [FRAC_W-1:0]        hard;
      logic [FRCP_W-1:0]        frcp;
      logic [FRAC_W+FRCP_W-1:0] fprod;
      unique case (stb_ff)
         STYLE_CONCEPT: begin
            hard = HARD_CO;
            frcp = FRCP_CO;
         end
         STYLE_PENCIL: begin
            hard = HARD_PE;
            frcp = FRCP_PE;
         end
         default: begin
            hard = HARD_CH;
            frcp = FRCP_CH;
         end
      endcase
      farc_in  = |db_ff[ROOT_W-1:FRAC_W];
      hardc_in = (db_ff[FRAC_W-1:0] <= hard);
      uc_in    = db_ff[FRAC_W-1:0] - hard;
      fprod    = (FRAC_W+FRCP_W)'(uc_in) * (FRAC_W+FRCP_W)'(frcp);
      efc_in   = fprod[2*FRAC_W:FRAC_W];
   end

   // Stage D: corrected quotient, falloff value
   always_comb begin
      logic [FRAC_W-1:0]   fdiv;
      logic [2*FRAC_W:0]   fchk;
      logic [FRAC_W:0]     fq;
      unique case (stc_ff)
         STYLE_CONCEPT: fdiv = FDIV_CO;
         STYLE_PENCIL:  fdiv = FDIV_PE;
         default:       fdiv = FDIV_CH;
      endcase
      fchk = (2*FRAC_W+1)'(efc_ff) * (2*FRAC_W+1)'(fdiv);
      if (fchk > (2*FRAC_W+1)'({uc_ff, {FRAC_W{1'b0}}})) begin
         fq = efc_ff - 1'b1;
      end else begin
         fq = efc_ff;
      end
      if (farc_ff) begin
         based_in = '0;
      end else if (hardc_ff) begin
         based_in = Q_ONE;
      end else begin
         based_in = Q_ONE - fq;
      end
   end

   // Stage E: falloff times grain
   assign prode_in = (2*FRAC_W+2)'(based_ff) * (2*FRAC_W+2)'(grd_ff);

   // Output stage: scale by 255, round half up, saturate; an undefined style code gives zero
   always_comb begin
      logic [2*FRAC_W+9:0] scaled;
      logic [9:0]          a;
      scaled = ((2*FRAC_W+10)'(prode_ff) << 8) - (2*FRAC_W+10)'(prode_ff)
               + ((2*FRAC_W+10)'(1) << (2*FRAC_W-1));
      a = scaled[2*FRAC_W+9:2*FRAC_W];
      case (ste_ff) inside
         STYLE_CHARCOAL, STYLE_CONCEPT, STYLE_PENCIL: begin
            rsp_tip_alpha_in = (a > 10'd255) ? 8'd255 : a[ALPHA_W-1:0];
         end
         default: rsp_tip_alpha_in = '0;
      endcase
   end

   // Registers: valid bits and configuration reset, payload not reset and held while reset is high
   always_ff @(posedge clock) begin
      if (reset) begin
         tip_style_ff <= STYLE_CHARCOAL;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         for (int j = 0; j < SQ_STAGES; j++) begin
            sq_ff[j].v <= 1'b0;
         end
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         ve_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tip_style_ff <= style_type'(csr_wr_data);
         end
         v0_ff  <= start;
         x0_ff  <= req_px_x;
         y0_ff  <= req_px_y;
         st0_ff <= tip_style_ff;

         v1_ff   <= v0_ff;
         d2_1_ff <= d2_1_in;
         n1_ff   <= n1_in;
         st1_ff  <= st0_ff;

         v2_ff   <= v1_ff;
         d2_2_ff <= d2_1_ff;
         p2_ff   <= p2_in;
         st2_ff  <= st1_ff;

         for (int j = 0; j < SQ_STAGES; j++) begin
            sq_ff[j] <= sq_in[j];
         end

         va_ff  <= sq_last.v;
         sta_ff <= sq_last.st;
         sa_ff  <= sq_last.root;
         dqa_ff <= dqa_in;
         pa_ff  <= sq_last.p;
         gqa_ff <= gqa_in;

         vb_ff  <= va_ff;
         stb_ff <= sta_ff;
         db_ff  <= db_in;
         grb_ff <= grb_in;

         vc_ff    <= vb_ff;
         stc_ff   <= stb_ff;
         farc_ff  <= farc_in;
         hardc_ff <= hardc_in;
         uc_ff    <= uc_in;
         efc_ff   <= efc_in;
         grc_ff   <= grb_ff;

         vd_ff    <= vc_ff;
         std_ff   <= stc_ff;
         based_ff <= based_in;
         grd_ff   <= grc_ff;

         ve_ff    <= vd_ff;
         ste_ff   <= std_ff;
         prode_ff <= prode_in;

         rsp_valid_ff     <= ve_ff;
         rsp_tip_alpha_ff <= rsp_tip_alpha_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tip_alpha = rsp_tip_alpha_ff;

endmodule

// ===== src/pbta_checker.sv =====
// Port-level checker for the procedural brush tip alpha block, bound to the top level.
module pbta_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [pbta_pkg::COORD_W-1:0]  req_px_x,
   input logic [pbta_pkg::COORD_W-1:0]  req_px_y,
   input logic                          rsp_valid,
   input logic [pbta_pkg::ALPHA_W-1:0]  rsp_tip_alpha
);
   import pbta_pkg::*;

   // Every taken transaction gives a response
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LAT rsp_valid)
      else $error("accepted transaction produced no response");

   // No response without a matching taken transaction
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LAT))
      else $error("response without a matching transaction");

   // The tip corner lies outside every radius
   a_corner_clear: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_px_x == '0 && req_px_y == '0)
         |-> ##PIPE_LAT (rsp_tip_alpha == '0))
      else $error("corner pixel is not transparent");

endmodule

bind procedural_brush_tip_alpha pbta_checker u_pbta_checker (.*);
